// File: src/fmmp_pkg.sv
// fibonacci modular matrix power: shared widths, constants and interface structs
// no dependencies, imported by every module of the block
`timescale 1ns / 1ps

package fmmp_pkg;

    localparam int INDEX_W    = 60;
    localparam int INDEX_BITS = 60;
    localparam int RES_W      = 30;
    localparam int MM_STEPS   = RES_W / 2;
    localparam int MM_CNT_W   = $clog2(MM_STEPS);

    localparam logic [RES_W-1:0] MODULUS_RESET = 30'd1000000009;

    typedef logic [RES_W-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word m;
        t_word a0;
        t_word a1;
        t_word b0;
        t_word b1;
    } t_mm_req;

    typedef struct packed {
        logic  done;
        t_word value;
    } t_mm_rsp;

    typedef struct packed {
        logic               start;
        logic [INDEX_W-1:0] index;
        t_word              m;
    } t_job;

    typedef struct packed {
        logic  busy;
        logic  valid;
        t_word value;
    } t_stat;

endpackage

// File: src/fmmp_mulmod.sv
// shared modular dot-product unit: (a0*b0 + a1*b1) mod m, two multiplier bits per cycle
// depends on fmmp_pkg
`timescale 1ns / 1ps

module fmmp_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fmmp_pkg::t_mm_req i_req,
    output fmmp_pkg::t_mm_rsp o_rsp
);
    import fmmp_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [MM_CNT_W-1:0] r_cnt;
    t_word               r_m;
    logic [RES_W:0]      r_m2;
    logic [RES_W+1:0]    r_m3;
    t_word               r_a0;
    t_word               r_a1;
    logic [RES_W:0]      r_sum;
    t_word               r_b0;
    t_word               r_b1;
    t_word               r_r;
    t_word               step_r;
    t_word               n_r;

    // one interleaved step: r = (2r + bits . a) mod m, with r, a0, a1 below m
    function automatic t_word mm_bit(
        input t_word            r,
        input logic             bx0,
        input logic             bx1,
        input t_word            a0,
        input t_word            a1,
        input logic [RES_W:0]   sum,
        input t_word            m,
        input logic [RES_W:0]   m2,
        input logic [RES_W+1:0] m3
    );
        logic [RES_W+1:0] t;
        logic [RES_W+1:0] s;
        unique case ({bx0, bx1})
            2'b11:   t = {1'b0, sum};
            2'b10:   t = {2'b00, a0};
            2'b01:   t = {2'b00, a1};
            default: t = '0;
        endcase
        s = {1'b0, r, 1'b0} + t;
        priority if (s >= m3) begin
            s = s - m3;
        end else if (s >= {1'b0, m2}) begin
            s = s - {1'b0, m2};
        end else if (s >= {2'b00, m}) begin
            s = s - {2'b00, m};
        end
        return s[RES_W-1:0];
    endfunction

    always_comb begin
        step_r = mm_bit(r_r, r_b0[RES_W-1], r_b1[RES_W-1], r_a0, r_a1, r_sum,
                        r_m, r_m2, r_m3);
        n_r    = mm_bit(step_r, r_b0[RES_W-2], r_b1[RES_W-2], r_a0, r_a1, r_sum,
                        r_m, r_m2, r_m3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MM_CNT_W'(MM_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - MM_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m   <= i_req.m;
            r_m2  <= {i_req.m, 1'b0};
            r_m3  <= {2'b00, i_req.m} + {1'b0, i_req.m, 1'b0};
            r_a0  <= i_req.a0;
            r_a1  <= i_req.a1;
            r_sum <= {1'b0, i_req.a0} + {1'b0, i_req.a1};
            r_b0  <= i_req.b0;
            r_b1  <= i_req.b1;
            r_r   <= '0;
        end else if (r_busy) begin
            r_r  <= n_r;
            r_b0 <= {r_b0[RES_W-3:0], 2'b00};
            r_b1 <= {r_b1[RES_W-3:0], 2'b00};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_r;

    a_busy_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("mulmod busy and done together");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && (r_cnt == '0) && !i_req.start |=> r_done)
        else $error("mulmod missed done after last step");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && (r_m != '0) && $past(r_a0 < r_m) && $past(r_a1 < r_m) |-> r_r < r_m)
        else $error("mulmod result not reduced");

endmodule

// File: src/fmmp_ctrl.sv
// sequencer: square-and-multiply over the index bits, one matrix entry per unit pass
// depends on fmmp_pkg, drives fmmp_mulmod through its request and response structs
`timescale 1ns / 1ps

module fmmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fmmp_pkg::t_job    i_job,
    input  logic              i_res_take,
    output fmmp_pkg::t_stat   o_stat,
    output fmmp_pkg::t_mm_req o_req,
    input  fmmp_pkg::t_mm_rsp i_rsp
);
    import fmmp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NEXT   = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_HOLD   = 3'd5;

    localparam logic PH_MUL = 1'b0;
    localparam logic PH_SQR = 1'b1;

    logic [2:0]            r_state;
    logic [1:0]            r_ent;
    logic                  r_phase;
    t_word                 r_m;
    logic [INDEX_BITS-1:0] r_idx;
    t_word                 r_acc  [4];
    t_word                 r_base [4];
    t_word                 r_tmp  [4];
    t_word                 r_res;
    t_word                 one_val;

    // operands reduced up front, so a modulus of one starts from all zeros
    assign one_val = (i_job.m == RES_W'(1)) ? '0 : RES_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ent   <= '0;
            r_phase <= PH_MUL;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.start) begin
                        r_state <= (i_job.m == '0) ? S_HOLD : S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_idx == '0) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_ent   <= '0;
                        r_phase <= r_idx[0] ? PH_MUL : PH_SQR;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_rsp.done) begin
                        if (r_ent == 2'd3) begin
                            r_state <= S_COMMIT;
                        end else begin
                            r_ent   <= r_ent + 2'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_COMMIT: begin
                    r_state <= S_NEXT;
                end
                S_HOLD: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_job.start) begin
                    r_m       <= i_job.m;
                    r_idx     <= i_job.index[INDEX_BITS-1:0];
                    r_acc[0]  <= one_val;
                    r_acc[1]  <= '0;
                    r_acc[2]  <= '0;
                    r_acc[3]  <= one_val;
                    r_base[0] <= one_val;
                    r_base[1] <= one_val;
                    r_base[2] <= one_val;
                    r_base[3] <= '0;
                    r_res     <= '0;
                end
            end
            S_NEXT: begin
                if (r_idx == '0) begin
                    r_res <= r_acc[1];
                end
            end
            S_WAIT: begin
                if (i_rsp.done) begin
                    r_tmp[r_ent] <= i_rsp.value;
                end
            end
            S_COMMIT: begin
                if (r_phase == PH_MUL) begin
                    r_acc    <= r_tmp;
                    r_idx[0] <= 1'b0;
                end else begin
                    r_base <= r_tmp;
                    r_idx  <= r_idx >> 1;
                end
            end
            default: begin
            end
        endcase
    end

    // entry (i, j) of x * base: x[i][0]*base[0][j] + x[i][1]*base[1][j]
    always_comb begin
        o_req.start = (r_state == S_ISSUE);
        o_req.m     = r_m;
        if (r_phase == PH_MUL) begin
            o_req.a0 = r_acc[{r_ent[1], 1'b0}];
            o_req.a1 = r_acc[{r_ent[1], 1'b1}];
        end else begin
            o_req.a0 = r_base[{r_ent[1], 1'b0}];
            o_req.a1 = r_base[{r_ent[1], 1'b1}];
        end
        o_req.b0 = r_base[{1'b0, r_ent[0]}];
        o_req.b1 = r_base[{1'b1, r_ent[0]}];
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.valid = (r_state == S_HOLD);
    assign o_stat.value = r_res;

endmodule

// File: src/fibonacci_mod_matrix_power_top.sv
// F(n) mod a configured modulus by 2x2 matrix power; one item in flight at a time
// each matrix product takes four unit passes, one per entry, plus a commit;
// there are (bit length of n + popcount of n - 1) products per item
// the next index is taken as soon as the sequencer is idle
// reset: synchronous active low, modulus returns to 1000000009, no result pending
// depends on fmmp_pkg, fmmp_mulmod and fmmp_ctrl
`timescale 1ns / 1ps

module fibonacci_mod_matrix_power_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [fmmp_pkg::INDEX_W-1:0] i_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [fmmp_pkg::RES_W-1:0]   o_fib_value,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fmmp_pkg::RES_W-1:0]   i_cfg_modulus
);
    import fmmp_pkg::*;

    t_word   r_modulus;
    logic    r_out_valid;
    t_word   r_fib;
    t_job    job;
    t_stat   stat;
    t_mm_req mm_req;
    t_mm_rsp mm_rsp;
    logic    out_take;
    logic    res_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = stat.busy;

    assign job.start = i_in_valid && !stat.busy;
    assign job.index = i_index;
    assign job.m     = r_modulus;

    assign out_take = r_out_valid && !i_out_stall;
    assign res_take = stat.valid && (!r_out_valid || out_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_modulus <= i_cfg_modulus;
            end
            if (res_take) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_fib <= stat.value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_fib_value = r_fib;

    fmmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_res_take (res_take),
        .o_stat     (stat),
        .o_req      (mm_req),
        .i_rsp      (mm_rsp)
    );

    fmmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

endmodule

// File: bench/tb_top.sv
// self-checking bench for fibonacci_mod_matrix_power_top: directed rows, then random indices
// over several modulus settings, every beat checked against a table value or an in-bench matrix power model
// depends on fmmp_pkg and fibonacci_mod_matrix_power_top
`timescale 1ns / 1ps

module tb_top;
    import fmmp_pkg::*;

    typedef logic [3:0][63:0] t_mat2;

    typedef struct {
        t_word              modulus;
        logic [INDEX_W-1:0] index;
        bit                 known;
        t_word              fib;
    } t_dir_row;

    typedef struct {
        logic [INDEX_W-1:0] index;
        t_word              modulus;
        t_word              fib;
    } t_fib_expect;

    localparam int    NUM_DIR        = 20;
    localparam int    NUM_PHASES     = 6;
    localparam int    RAND_PER_PHASE = 210;
    localparam int    TAIL_CYCLES    = 9000;
    localparam t_word MODULUS_MAX    = 30'h3FFFFFFF;
    localparam logic [INDEX_W-1:0] INDEX_ONES = {INDEX_W{1'b1}};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic [INDEX_W-1:0] in_index    = '0;
    logic               out_stall   = 1'b0;
    logic               cfg_valid   = 1'b0;
    t_word              cfg_modulus = '0;
    logic               in_stall;
    logic               out_valid;
    t_word              fib_value;
    logic               cfg_ready;

    t_fib_expect fib_pending[$];
    t_dir_row    dir_rows[NUM_DIR];
    t_word       cur_modulus = MODULUS_RESET;
    bit          no_idle     = 1'b0;
    int          stall_left  = 0;
    int          n_errors    = 0;
    int          n_checked   = 0;
    int          n_sent      = 0;
    int          n_settings  = 0;

    fibonacci_mod_matrix_power_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_index       (in_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_fib_value   (fib_value),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_modulus (cfg_modulus)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_mat2 mat_mul_mod(input t_mat2 x, input t_mat2 y, input logic [63:0] m);
        t_mat2       r;
        logic [63:0] s;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                s = 0;
                for (int k = 0; k < 2; k++) begin
                    s = s + (x[2*i+k] % m) * (y[2*k+j] % m);
                    s = s % m;
                end
                r[2*i+j] = s;
            end
        end
        return r;
    endfunction

    function automatic t_word fib_mod(input logic [INDEX_W-1:0] n, input t_word modulus);
        t_mat2       acc;
        t_mat2       base;
        logic [63:0] m;
        m = {34'd0, modulus};
        if (m == 0)
            return '0;
        acc  = {64'd1, 64'd0, 64'd0, 64'd1};
        base = {64'd0, 64'd1, 64'd1, 64'd1};
        for (int b = 0; b < INDEX_BITS; b++) begin
            if (n[b])
                acc = mat_mul_mod(acc, base, m);
            base = mat_mul_mod(base, base, m);
        end
        return t_word'(acc[1] % m);
    endfunction

    // mostly short indices keep the run short, a few reach the full width
    function automatic logic [INDEX_W-1:0] rand_index();
        int          sel;
        int          len;
        logic [63:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 3)
            len = 0;
        else if (sel < 70)
            len = $urandom_range(1, 8);
        else if (sel < 95)
            len = $urandom_range(9, 20);
        else if ($urandom_range(0, 3) == 0)
            len = INDEX_W;
        else
            len = $urandom_range(21, INDEX_W - 1);
        if (len == 0)
            return '0;
        v = {$urandom, $urandom};
        v = v & ((64'd1 << len) - 64'd1);
        v[len-1] = 1'b1;
        return v[INDEX_W-1:0];
    endfunction

    task automatic send_index(input logic [INDEX_W-1:0] idx, input t_word fib);
        int          gap;
        t_fib_expect e;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_index <= idx;
        do @(posedge clk); while (in_stall);
        e.index   = idx;
        e.modulus = cur_modulus;
        e.fib     = fib;
        fib_pending.push_back(e);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (fib_pending.size() != 0);
    endtask

    task automatic write_modulus(input t_word v);
        cfg_valid   <= 1'b1;
        cfg_modulus <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_modulus = v;
        n_settings++;
    endtask

    // result side: random stall per beat, checked in order of acceptance
    always @(posedge clk) begin
        t_fib_expect e;
        if (rst_n && out_valid && !out_stall) begin
            n_checked++;
            if (fib_pending.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected beat, expected none, got fib_value %0d",
                         $time, fib_value);
            end else begin
                e = fib_pending.pop_front();
                if (fib_value !== e.fib) begin
                    n_errors++;
                    $display("%0t ns: index %0d mod %0d, expected fib_value %0d, got %0d",
                             $time, e.index, e.modulus, e.fib, fib_value);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 6);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    initial begin
        t_word              phase_mod;
        logic [INDEX_W-1:0] idx;
        dir_rows = '{
            '{MODULUS_RESET, 60'd0,               1'b1, 30'd0},
            '{MODULUS_RESET, 60'd1,               1'b1, 30'd1},
            '{MODULUS_RESET, 60'd2,               1'b1, 30'd1},
            '{MODULUS_RESET, 60'd10,              1'b1, 30'd55},
            '{MODULUS_RESET, INDEX_ONES,          1'b0, 30'd0},
            '{MODULUS_RESET, 60'h800000000000000, 1'b0, 30'd0},
            '{MODULUS_RESET, 60'h555555555555555, 1'b0, 30'd0},
            '{MODULUS_RESET, 60'hAAAAAAAAAAAAAAA, 1'b0, 30'd0},
            '{MODULUS_MAX,   INDEX_ONES,          1'b0, 30'd0},
            '{MODULUS_MAX,   60'd12,              1'b1, 30'd144},
            '{MODULUS_MAX,   60'd45,              1'b0, 30'd0},
            '{30'd2,         60'd1,               1'b1, 30'd1},
            '{30'd2,         60'd3,               1'b1, 30'd0},
            '{30'd2,         INDEX_ONES,          1'b0, 30'd0},
            '{30'd0,         60'd5,               1'b1, 30'd0},
            '{30'd0,         INDEX_ONES,          1'b1, 30'd0},
            '{30'd1,         60'd7,               1'b1, 30'd0},
            '{30'd1,         60'd1,               1'b1, 30'd0},
            '{MODULUS_RESET, 60'd90,              1'b0, 30'd0},
            '{MODULUS_RESET, 60'd44,              1'b1, 30'd701408733}
        };
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].modulus != cur_modulus) begin
                drain_results();
                write_modulus(dir_rows[r].modulus);
            end
            send_index(dir_rows[r].index,
                       dir_rows[r].known ? dir_rows[r].fib
                                         : fib_mod(dir_rows[r].index, cur_modulus));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: phase_mod = t_word'($urandom_range(2, MODULUS_MAX));
                1: phase_mod = MODULUS_MAX;
                2: phase_mod = t_word'($urandom_range(2, 64));
                3: phase_mod = 30'd2;
                4: phase_mod = t_word'($urandom);
                default: phase_mod = MODULUS_RESET;
            endcase
            drain_results();
            write_modulus(phase_mod);
            no_idle = (p == 3);
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (k == RAND_PER_PHASE / 2)
                    drain_results();
                idx = rand_index();
                send_index(idx, fib_mod(idx, cur_modulus));
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d indices (%0d directed) over %0d modulus writes",
                 n_sent, NUM_DIR, n_settings);
        $display("%0d result beats checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0 && fib_pending.size() == 0) begin
            $display("PASS fibonacci_mod_matrix_power_top");
        end else begin
            $display("FAIL fibonacci_mod_matrix_power_top");
        end
        $finish;
    end

    initial begin
        #600_000_000;
        $display("timeout with %0d results outstanding", fib_pending.size());
        $display("FAIL fibonacci_mod_matrix_power_top");
        $finish;
    end

endmodule
